FILE: design/yfr_pkg.sv
package yfr_pkg;

  localparam int DIM_W  = 10;
  localparam int BYTE_W = 8;
  localparam int CIDX_W = 2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd2;

  localparam int DIM_CAP = (1 << DIM_W) - 2;

  typedef enum logic [1:0] {
    MODE_PLANAR      = 2'd0,
    MODE_SEMI_FLIP   = 2'd1,
    MODE_SEMI_ROT270 = 2'd2
  } mode_e;

  typedef struct packed {
    logic settle;
    logic advance;
  } seq_ctl_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] v;
    v = {raw[DIM_W-1:1], 1'b0};
    if (v < DIM_W'(2)) v = DIM_W'(2);
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

FILE: design/yfr_emit_seq.sv
module yfr_emit_seq #(
  parameter int ADDR_W = 19
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  yfr_pkg::seq_ctl_t              ctl_i,
  input  yfr_pkg::mode_e                 mode_i,
  input  logic [yfr_pkg::DIM_W-1:0]      width_i,
  input  logic [yfr_pkg::DIM_W-1:0]      height_i,
  input  logic [ADDR_W-1:0]              size_i,
  output logic [ADDR_W-1:0]              rd_addr_o,
  output logic                           last_o,
  output logic [ADDR_W-1:0]              total_m1_o
);

  typedef enum logic [1:0] {
    REG_LUMA     = 2'd0,
    REG_CHROMA_U = 2'd1,
    REG_CHROMA_V = 2'd2
  } region_e;

  localparam logic [ADDR_W-1:0] ONE = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] TWO = ADDR_W'(2);

  // frame geometry, refreshed in the settle cycle
  logic [ADDR_W-1:0] total_m1_q, size_m1_q, uend_m1_q;
  logic [ADDR_W-1:0] luma_start_q, c0_start_q, c1_start_q;
  logic [ADDR_W-1:0] luma_step_q, ceven_q, codd_q, crdec_q;
  logic [yfr_pkg::DIM_W-1:0] lrow_m1_q, crow_m1_q;
  logic planar_q;

  logic [ADDR_W-1:0] wa, wc, usize, total;
  logic [ADDR_W-1:0] total_m1_d, size_m1_d, uend_m1_d;
  logic [ADDR_W-1:0] luma_start_d, c0_start_d, c1_start_d;
  logic [ADDR_W-1:0] luma_step_d, ceven_d, codd_d, crdec_d;
  logic [yfr_pkg::DIM_W-1:0] lrow_m1_d, crow_m1_d;
  logic planar, rot;

  always_comb begin
    wa     = ADDR_W'(width_i);
    wc     = wa >> 1;
    usize  = size_i >> 2;
    total  = size_i + (size_i >> 1);
    planar = (mode_i == yfr_pkg::MODE_PLANAR);
    rot    = (mode_i == yfr_pkg::MODE_SEMI_ROT270);
    total_m1_d   = total - ONE;
    size_m1_d    = size_i - ONE;
    uend_m1_d    = size_i + usize - ONE;
    luma_start_d = rot ? (wa - ONE) : (size_i - ONE);
    luma_step_d  = rot ? wa : ('0 - wa);
    c1_start_d   = total - ONE;
    if (planar) begin
      c0_start_d = size_i + usize - ONE;
      ceven_d    = '0 - wc;
      codd_d     = '0 - wc;
      crdec_d    = ONE;
      crow_m1_d  = (height_i >> 1) - yfr_pkg::DIM_W'(1);
    end else begin
      c0_start_d = rot ? (size_i + wa - TWO) : (total - TWO);
      ceven_d    = ONE;
      codd_d     = rot ? (wa - ONE) : ('0 - wa - ONE);
      crdec_d    = TWO;
      crow_m1_d  = height_i - yfr_pkg::DIM_W'(1);
    end
    lrow_m1_d = height_i - yfr_pkg::DIM_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.settle) begin
      total_m1_q   <= total_m1_d;
      size_m1_q    <= size_m1_d;
      uend_m1_q    <= uend_m1_d;
      luma_start_q <= luma_start_d;
      c0_start_q   <= c0_start_d;
      c1_start_q   <= c1_start_d;
      luma_step_q  <= luma_step_d;
      ceven_q      <= ceven_d;
      codd_q       <= codd_d;
      crdec_q      <= crdec_d;
      lrow_m1_q    <= lrow_m1_d;
      crow_m1_q    <= crow_m1_d;
      planar_q     <= planar;
    end
  end

  // walk state
  logic [ADDR_W-1:0]         pos_q, addr_q, base_q;
  logic [yfr_pkg::DIM_W-1:0] col_q;
  region_e                   region_q;

  logic                      last, row_end, in_luma;
  logic [ADDR_W-1:0]         step, rdec, base_next;

  always_comb begin
    in_luma   = (region_q == REG_LUMA);
    last      = (pos_q == total_m1_q);
    row_end   = (col_q == (in_luma ? lrow_m1_q : crow_m1_q));
    step      = in_luma ? luma_step_q : (col_q[0] ? codd_q : ceven_q);
    rdec      = in_luma ? ONE : crdec_q;
    base_next = base_q - rdec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      col_q    <= '0;
      addr_q   <= '0;
      base_q   <= '0;
      region_q <= REG_LUMA;
    end else if (ctl_i.settle) begin
      pos_q    <= '0;
      col_q    <= '0;
      addr_q   <= luma_start_d;
      base_q   <= luma_start_d;
      region_q <= REG_LUMA;
    end else if (ctl_i.advance) begin
      priority if (last) begin
        pos_q    <= '0;
        col_q    <= '0;
        addr_q   <= luma_start_q;
        base_q   <= luma_start_q;
        region_q <= REG_LUMA;
      end else if (pos_q == size_m1_q) begin
        pos_q    <= pos_q + ONE;
        col_q    <= '0;
        addr_q   <= c0_start_q;
        base_q   <= c0_start_q;
        region_q <= REG_CHROMA_U;
      end else if (planar_q && pos_q == uend_m1_q) begin
        pos_q    <= pos_q + ONE;
        col_q    <= '0;
        addr_q   <= c1_start_q;
        base_q   <= c1_start_q;
        region_q <= REG_CHROMA_V;
      end else if (row_end) begin
        pos_q  <= pos_q + ONE;
        col_q  <= '0;
        addr_q <= base_next;
        base_q <= base_next;
      end else begin
        pos_q  <= pos_q + ONE;
        col_q  <= col_q + yfr_pkg::DIM_W'(1);
        addr_q <= addr_q + step;
      end
    end
  end

  assign rd_addr_o  = addr_q;
  assign last_o     = last;
  assign total_m1_o = total_m1_q;

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.settle |-> pos_q <= total_m1_q)
    else $error("emit position beyond frame");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.settle |-> col_q <= (in_luma ? lrow_m1_q : crow_m1_q))
    else $error("emit column beyond row");

endmodule

FILE: design/yuv420_frame_rotate.sv
// channel   direction  handshake          payload
// item in   input      start_i, busy_o    op_i, src_byte_i
// result    output     done_o (strobe)    dst_byte_o, frame_end_o
// config    input      cfg_we_i           cfg_idx_i, cfg_data_i
//
// one item per cycle while busy_o is low; a pull shows its byte in the next cycle
// the emit address walks by add and subtract, the frame memory has one write
// and one registered read port, so store and pull items can interleave freely
// busy_o is high for one cycle after reset and after each register write,
// while the frame size product settles into the address walk
// the receiver cannot stall: done_o is a one-cycle strobe
module yuv420_frame_rotate #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [yfr_pkg::BYTE_W-1:0]    src_byte_i,
  input  logic                          cfg_we_i,
  input  logic [yfr_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [yfr_pkg::DIM_W-1:0]     cfg_data_i,
  output logic                          done_o,
  output logic [yfr_pkg::BYTE_W-1:0]    dst_byte_o,
  output logic                          frame_end_o
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT + (MAX_WIDTH * MAX_HEIGHT) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int W_LIM_I     = ((MAX_WIDTH & ~1) > yfr_pkg::DIM_CAP) ?
                               yfr_pkg::DIM_CAP : (MAX_WIDTH & ~1);
  localparam int H_LIM_I     = ((MAX_HEIGHT & ~1) > yfr_pkg::DIM_CAP) ?
                               yfr_pkg::DIM_CAP : (MAX_HEIGHT & ~1);
  localparam logic [yfr_pkg::DIM_W-1:0] W_LIM = yfr_pkg::DIM_W'(W_LIM_I);
  localparam logic [yfr_pkg::DIM_W-1:0] H_LIM = yfr_pkg::DIM_W'(H_LIM_I);
  localparam logic [yfr_pkg::DIM_W-1:0] W_RST =
    yfr_pkg::eff_dim(yfr_pkg::DIM_W'(176), W_LIM);
  localparam logic [yfr_pkg::DIM_W-1:0] H_RST =
    yfr_pkg::eff_dim(yfr_pkg::DIM_W'(144), H_LIM);
  localparam int SIZE_RST_I = int'(W_RST) * int'(H_RST);
  localparam logic [ADDR_W-1:0] SIZE_RST = ADDR_W'(SIZE_RST_I);

  logic [yfr_pkg::DIM_W-1:0]   w_q, h_q, w_new, h_new;
  logic [2*yfr_pkg::DIM_W-1:0] prod;
  logic [ADDR_W-1:0]           size_q, load_q, total_m1, rd_addr;
  yfr_pkg::mode_e              mode_q, mode_new;
  logic                        pend_q, cfg_hit, acc, store_acc, emit_acc, last;

  always_comb begin
    cfg_hit = cfg_we_i && (cfg_idx_i == yfr_pkg::CFG_WIDTH ||
                           cfg_idx_i == yfr_pkg::CFG_HEIGHT ||
                           cfg_idx_i == yfr_pkg::CFG_MODE);
    w_new    = w_q;
    h_new    = h_q;
    mode_new = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        yfr_pkg::CFG_WIDTH:  w_new = yfr_pkg::eff_dim(cfg_data_i, W_LIM);
        yfr_pkg::CFG_HEIGHT: h_new = yfr_pkg::eff_dim(cfg_data_i, H_LIM);
        yfr_pkg::CFG_MODE: begin
          if (cfg_data_i[1:0] > yfr_pkg::MODE_SEMI_ROT270) begin
            mode_new = yfr_pkg::MODE_SEMI_ROT270;
          end else begin
            mode_new = yfr_pkg::mode_e'(cfg_data_i[1:0]);
          end
        end
        default: ;
      endcase
    end
    prod      = w_new * h_new;
    acc       = start_i && !busy_o;
    store_acc = acc && (op_i == yfr_pkg::OP_STORE);
    emit_acc  = acc && (op_i == yfr_pkg::OP_EMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= W_RST;
      h_q    <= H_RST;
      size_q <= SIZE_RST;
      mode_q <= yfr_pkg::MODE_PLANAR;
      pend_q <= 1'b1;
      load_q <= '0;
    end else if (cfg_hit) begin
      w_q    <= w_new;
      h_q    <= h_new;
      size_q <= ADDR_W'(prod);
      mode_q <= mode_new;
      pend_q <= 1'b1;
      load_q <= '0;
    end else begin
      pend_q <= 1'b0;
      if (store_acc) load_q <= (load_q == total_m1) ? '0 : load_q + ADDR_W'(1);
    end
  end

  assign busy_o = pend_q;

  yfr_pkg::seq_ctl_t seq_ctl;
  assign seq_ctl.settle  = pend_q;
  assign seq_ctl.advance = emit_acc;

  yfr_emit_seq #(
    .ADDR_W (ADDR_W)
  ) u_emit_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (seq_ctl),
    .mode_i     (mode_q),
    .width_i    (w_q),
    .height_i   (h_q),
    .size_i     (size_q),
    .rd_addr_o  (rd_addr),
    .last_o     (last),
    .total_m1_o (total_m1)
  );

  // frame memory
  logic [yfr_pkg::BYTE_W-1:0] mem_q [STORE_DEPTH];
  logic [yfr_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (store_acc) mem_q[load_q] <= src_byte_i;
    if (emit_acc) rd_data_q <= mem_q[rd_addr];
  end

  logic done_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      end_q  <= 1'b0;
    end else begin
      done_q <= emit_acc;
      end_q  <= emit_acc && last;
    end
  end

  assign done_o      = done_q;
  assign dst_byte_o  = rd_data_q;
  assign frame_end_o = end_q;

  a_done_follows_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(emit_acc))
    else $error("result without a pull item");

  a_cfg_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> busy_o)
    else $error("no settle cycle after register write");

  a_end_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |-> done_o)
    else $error("frame end without result");

  a_load_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_acc |-> load_q <= total_m1)
    else $error("load position beyond frame");

endmodule
